// ===== src/fspl_pkg.sv =====
// ----------------------------------------------------------------------------
// fspl_pkg
// Shared types and constants for the free-space path loss pipeline.
// ----------------------------------------------------------------------------
package fspl_pkg;

  // Normalized mantissa, value in [1,2) with 30 fraction bits
  typedef logic [30:0] mant_t;

  localparam int MANT_FRAC = 30;

  // 20*log10(2) in tenths of a dB, scaled by 1000
  localparam logic [15:0] SCALE_NUM = 16'd60206;

  // ceil(2^30/1000), exact for dividends below 2^21
  localparam logic [20:0] RECIP_1000 = 21'd1073742;
  localparam int RECIP_1000_SHIFT = 30;

  // ceil(2^16/10), exact for dividends below 2^14
  localparam logic [12:0] RECIP_10 = 13'd6554;
  localparam int RECIP_10_SHIFT = 16;

  localparam logic [9:0] OFFSET_RESET = 10'd312;
  localparam logic [11:0] ROUND_HALF = 12'd5;

  // Stages outside the squaring chain
  localparam int STAGES_FIXED = 5;

  localparam logic [8:0] LOSS_MAX = 9'd289;
  localparam logic [8:0] CLAMP_LOSS_MAX = 9'd103;

endpackage

// ===== src/free_space_path_loss_db_top.sv =====
// ----------------------------------------------------------------------------
// free_space_path_loss_db_top
// Throughput: one word per cycle; busy stays low, one squaring stage per
// fraction bit sets the depth. Reset clears all stage valids and loads the
// offset register with 312. done marks loss_db for exactly one cycle.
// ----------------------------------------------------------------------------
module free_space_path_loss_db_top #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic signed [31:0] range_metres,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [9:0]        offset_tenths,
  output logic              done,
  output logic [8:0]        loss_db
);

  localparam int L2W = 5 + FRACTION_BITS;

  logic [9:0] offset;

  logic        in_vld;
  logic [31:0] in_raw;

  logic [30:0] x_clamp;
  logic [4:0]  lead;
  fspl_pkg::mant_t norm;

  logic [FRACTION_BITS:0] sq_vld;
  fspl_pkg::mant_t        sq_m   [0:FRACTION_BITS];
  logic [L2W-1:0]         sq_acc [0:FRACTION_BITS];

  logic [L2W+15:0] scaled;
  logic            sc_vld;
  logic [20:0]     sc;

  logic [41:0] rp;
  logic        tn_vld;
  logic [10:0] tenths;

  logic [11:0] sum;
  logic [24:0] dp;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= fspl_pkg::OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      offset <= offset_tenths;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      sq_vld <= '0;
      sc_vld <= 1'b0;
      tn_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      in_vld <= start && !busy;
      sq_vld <= {sq_vld[FRACTION_BITS-1:0], in_vld};
      sc_vld <= sq_vld[FRACTION_BITS];
      tn_vld <= sc_vld;
      done   <= tn_vld;
    end
  end

  always_ff @(posedge clk) begin
    in_raw <= range_metres;
  end

  // Clamp, leading one, normalize
  always_comb begin
    x_clamp = (in_raw[31] || in_raw == 32'd0) ? 31'd1 : in_raw[30:0];
    lead = '0;
    for (int i = 0; i < 31; i++) begin
      if (x_clamp[i]) begin
        lead = 5'(i);
      end
    end
    norm = x_clamp << (5'(fspl_pkg::MANT_FRAC) - lead);
  end

  always_ff @(posedge clk) begin
    sq_m[0]   <= norm;
    sq_acc[0] <= L2W'(lead) << FRACTION_BITS;
  end

  // One squaring per fraction bit
  for (genvar g = 1; g <= FRACTION_BITS; g++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] sqr;

    assign prod = 62'(sq_m[g-1]) * 62'(sq_m[g-1]);
    assign sqr  = prod[61:30];

    always_ff @(posedge clk) begin
      sq_m[g]   <= sqr[31] ? sqr[31:1] : sqr[30:0];
      sq_acc[g] <= sq_acc[g-1] | (sqr[31] ? (L2W'(1) << (FRACTION_BITS - g)) : '0);
    end
  end

  // Scale to tenths of a dB, drop fraction
  assign scaled = (L2W+16)'(sq_acc[FRACTION_BITS]) * (L2W+16)'(fspl_pkg::SCALE_NUM);

  always_ff @(posedge clk) begin
    sc <= scaled[FRACTION_BITS +: 21];
  end

  // Divide by 1000
  assign rp = 42'(sc) * 42'(fspl_pkg::RECIP_1000);

  always_ff @(posedge clk) begin
    tenths <= rp[fspl_pkg::RECIP_1000_SHIFT +: 11];
  end

  // Add offset, round half up, divide by 10
  assign sum = 12'(tenths) + 12'(offset) + fspl_pkg::ROUND_HALF;
  assign dp  = 25'(sum) * 25'(fspl_pkg::RECIP_10);

  always_ff @(posedge clk) begin
    loss_db <= dp[fspl_pkg::RECIP_10_SHIFT +: 9];
  end

endmodule

// ===== src/fspl_chk.sv =====
// ----------------------------------------------------------------------------
// fspl_chk
// Port-level checks on latency, result range and clamped ranges.
// ----------------------------------------------------------------------------
module fspl_chk #(
  parameter int FRACTION_BITS = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic signed [31:0] range_metres,
  input logic              done,
  input logic [8:0]        loss_db
);

  localparam int LAT = FRACTION_BITS + fspl_pkg::STAGES_FIXED;

  logic acc_in;
  logic acc_clamp;

  assign acc_in    = start && !busy;
  assign acc_clamp = acc_in && (range_metres[31] || range_metres == 32'sd0);

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc_in, LAT))
    else $error("done without an accepted word");

  a_word_gives_done: assert property (@(posedge clk) disable iff (rst)
    acc_in |-> ##LAT done)
    else $error("accepted word produced no result");

  a_loss_range: assert property (@(posedge clk) disable iff (rst)
    done |-> loss_db <= fspl_pkg::LOSS_MAX)
    else $error("loss_db out of range");

  a_clamp_loss: assert property (@(posedge clk) disable iff (rst)
    (done && $past(acc_clamp, LAT)) |-> loss_db <= fspl_pkg::CLAMP_LOSS_MAX)
    else $error("clamped range gave excess loss");

endmodule

bind free_space_path_loss_db_top fspl_chk #(
  .FRACTION_BITS(FRACTION_BITS)
) u_fspl_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .range_metres (range_metres),
  .done         (done),
  .loss_db      (loss_db)
);

// ===== test/free_space_path_loss_db_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_space_path_loss_db_top_tb
// Self-checking bench for the path loss pipeline. A driver pushes ranges
// with random gaps and a monitor checks every done strobe in order against
// a bit-accurate loss calculation. The offset register is rewritten between
// drained phases, including both ends of its field.
// ----------------------------------------------------------------------------
module free_space_path_loss_db_top_tb;

  localparam int FRACTION_BITS = 16;
  localparam int LATENCY = FRACTION_BITS + fspl_pkg::STAGES_FIXED;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 9;
  localparam int WORDS_PER_PHASE = 125;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] range_metres = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [9:0]         offset_tenths = '0;
  logic               done;
  logic [8:0]         loss_db;

  logic signed [31:0] range_q[$];
  logic [8:0]         expected_loss_q[$];
  logic [9:0]         offset_model = fspl_pkg::OFFSET_RESET;
  logic [8:0]         loss_want;
  int                 mismatches = 0;
  int                 words_in = 0;
  int                 words_out = 0;
  int                 clamped_words = 0;
  int                 cfg_writes = 0;
  int                 idle_cycles = 0;

  free_space_path_loss_db_top #(
    .FRACTION_BITS(FRACTION_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .range_metres(range_metres),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .offset_tenths(offset_tenths),
    .done(done),
    .loss_db(loss_db)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // log2 with FRACTION_BITS fraction bits, one bit per mantissa squaring
  function automatic logic [63:0] log2_fixed(input logic [31:0] x);
    int          lead;
    int          i;
    logic [63:0] acc;
    logic [63:0] m;
    lead = 0;
    while (lead < 31 && (x >> (lead + 1)) != 0)
      lead++;
    acc = 64'(lead) << FRACTION_BITS;
    m = 64'(x) << (30 - lead);
    for (i = 1; i <= FRACTION_BITS; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        acc += 64'd1 << (FRACTION_BITS - i);
      end
    end
    return acc;
  endfunction

  function automatic logic [8:0] predict_loss_db(input logic signed [31:0] r,
                                                 input logic [9:0] offset);
    logic [31:0] clamped;
    logic [63:0] tenths;
    clamped = (r[31] || r == 0) ? 32'd1 : r;
    tenths = ((log2_fixed(clamped) * 64'd60206) / 64'd1000) >> FRACTION_BITS;
    tenths += offset;
    return 9'((tenths + 64'd5) / 64'd10);
  endfunction

  function automatic logic signed [31:0] random_range();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 16);
      2: return (32'sd1 <<< k) + $urandom_range(0, 2) - 1;
      3: return -$urandom_range(1, 1000);
      default: return $urandom >> $urandom_range(1, 31);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic write_offset(input logic [9:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    offset_tenths <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    offset_model = v;
    cfg_writes++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (range_q.size() != 0 || start || expected_loss_q.size() != 0);
  endtask

  // driver: no gaps for a stretch of words in the middle of the run
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_loss_q.push_back(predict_loss_db(range_metres, offset_model));
        if (range_metres[31] || range_metres == 0)
          clamped_words++;
        words_in++;
      end
      if (!start || !busy) begin
        if (range_q.size() != 0 &&
            !((words_in < 400 || words_in >= 650) && $urandom_range(0, 99) < 18)) begin
          start <= 1'b1;
          range_metres <= range_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_loss_q.size() == 0) begin
        report_mismatch($sformatf("loss_db %0d with no word pending", loss_db));
      end else begin
        loss_want = expected_loss_q.pop_front();
        if (loss_db !== loss_want)
          report_mismatch($sformatf("word %0d loss_db %0d, want %0d",
                                    words_out, loss_db, loss_want));
        words_out++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("free_space_path_loss_db_top test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [31:0] directed[] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd2, 32'sd3, 32'sd1000, 32'sd1023, 32'sd1024,
      32'sd65535, 32'sd65536, 32'sh3FFF_FFFF, 32'sh4000_0000, 32'sh7FFF_FFFF,
      32'sh8000_0000, 32'sh8000_0001, 32'sh5555_5555, 32'sh2AAA_AAAA,
      32'sd3_000_000, 32'sd384_400_000, 32'sd7};
    logic [9:0] offset_plan[PHASES];
    int p;
    int n;
    offset_plan = '{fspl_pkg::OFFSET_RESET, 10'd0, 10'd1000, 10'd1023, 10'd1001,
                    10'd5, 10'd995, 10'd0, fspl_pkg::OFFSET_RESET};
    offset_plan[7] = $urandom_range(0, 1023);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (p = 0; p < PHASES; p++) begin
      if (p != 0)
        write_offset(offset_plan[p]);
      @(negedge clk);
      if (p == 0) begin
        foreach (directed[i])
          range_q.push_back(directed[i]);
      end else begin
        range_q.push_back(32'sd0);
        range_q.push_back(32'sh7FFF_FFFF);
      end
      for (n = 0; n < WORDS_PER_PHASE; n++)
        range_q.push_back(random_range());
      wait_drained();
    end
    repeat (LATENCY + 10) @(posedge clk);
    while (expected_loss_q.size() != 0)
      report_mismatch($sformatf("loss_db %0d never arrived", expected_loss_q.pop_front()));
    $display("%0d ranges checked (%0d clamped to 1 m) over %0d offset writes",
             words_out, clamped_words, cfg_writes);
    if (mismatches == 0)
      $display("free_space_path_loss_db_top test passed");
    else
      $display("free_space_path_loss_db_top test failed");
    $finish;
  end

endmodule

// ===== free_space_path_loss_db_top.f =====
src/fspl_pkg.sv
src/free_space_path_loss_db_top.sv
src/fspl_chk.sv
test/free_space_path_loss_db_top_tb.sv
